// ===== design/mpq_pkg.sv =====
package mpq_pkg;

	// Queue geometry
	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int CNT_OUT_W = 7;

	// Operation codes carried on func
	typedef enum logic [1:0] {
		FUNC_INSERT  = 2'd0,
		FUNC_EXTRACT = 2'd1,
		FUNC_PEEK    = 2'd2,
		FUNC_RSVD    = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic             ins;
		logic             ext;
		logic [VAL_W-1:0] value;
	} mpq_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic             gt;
	} mpq_link_t;

endpackage

// ===== design/max_priority_queue.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall func, value
// rsp       out        rsp_valid/rsp_stall max_value, status, count
//
// One transaction per cycle while req is not stalled: a row of CAPACITY cells keeps
// the values sorted, largest in the first cell; an insert shifts the cells below its
// place down, an extract shifts every cell up. Each result is registered in the output register.
// arst_n empties every cell and the output register at once; no sweep.
// A stalled result stalls req only while the output register is occupied.
module max_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  func,
	input  logic signed [31:0]          value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic signed [31:0]          max_value,
	output logic [1:0]                  status,
	output logic [6:0]                  count
);
	import mpq_pkg::*;

	logic                 accept;
	func_t                func_op;
	logic                 empty;
	logic                 full;
	mpq_cmd_t             cmd;
	mpq_link_t            links [CAPACITY];
	mpq_link_t            top_link;
	mpq_link_t            bottom_link;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 rsp_valid_q;
	logic [VAL_W-1:0]     max_value_q;
	status_t              status_q;
	status_t              status_nxt;
	logic [VAL_W-1:0]     max_nxt;
	logic [CNT_OUT_W-1:0] count_out_q;

	// Accept while the output register is free or draining
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign func_op   = func_t'(func);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(CAPACITY));

	// Decode the operation for the cells and the result
	always_comb begin
		cmd.ins    = 1'b0;
		cmd.ext    = 1'b0;
		cmd.value  = value;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		max_nxt    = '0;
		case (func_op)
			FUNC_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.ins   = accept;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			FUNC_EXTRACT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.ext   = accept;
					count_nxt = count_q - CNT_W'(1);
					max_nxt   = links[0].value;
				end
			end
			default: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					max_nxt = links[0].value;
				end
			end
		endcase
	end

	// Chain ends: nothing above the head, an empty slot below the tail
	assign top_link    = '{valid: 1'b0, value: '0, gt: 1'b0};
	assign bottom_link = '{valid: 1'b0, value: '0, gt: 1'b1};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.up_link   ((i == 0) ? top_link : links[(i == 0) ? 0 : i - 1]),
			.down_link ((i == CAPACITY - 1) ? bottom_link
			            : links[(i == CAPACITY - 1) ? i : i + 1]),
			.link      (links[i])
		);
	end

	// Hold the element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			max_value_q <= max_nxt;
			status_q    <= status_nxt;
			count_out_q <= CNT_OUT_W'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign max_value = max_value_q;
	assign status    = status_q;
	assign count     = count_out_q;

endmodule

// ===== design/mpq_cell.sv =====
module mpq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mpq_pkg::mpq_cmd_t  cmd,
	input  mpq_pkg::mpq_link_t up_link,
	input  mpq_pkg::mpq_link_t down_link,
	output mpq_pkg::mpq_link_t link
);
	import mpq_pkg::*;

	logic             valid_q;
	logic [VAL_W-1:0] value_q;
	logic             gt;

	// An empty slot counts as minus infinity: any new value beats it
	assign gt = !valid_q || ($signed(cmd.value) > $signed(value_q));

	assign link.valid = valid_q;
	assign link.value = value_q;
	assign link.gt    = gt;

	// Occupancy: shift down on insert, shift up on extract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && gt) begin
			valid_q <= up_link.gt ? up_link.valid : 1'b1;
		end else if (cmd.ext) begin
			valid_q <= down_link.valid;
		end
	end

	// Stored value follows the same move as the occupancy bit
	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			value_q <= up_link.gt ? up_link.value : cmd.value;
		end else if (cmd.ext) begin
			value_q <= down_link.value;
		end
	end

endmodule
